/* rtl/oled_text_cursor_renderer_unit_macros.svh */
// Assertion macros for the OLED text console block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef OLED_TEXT_CURSOR_RENDERER_UNIT_MACROS_SVH
`define OLED_TEXT_CURSOR_RENDERER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define OTCR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otcr check failed");

// next-cycle implication, disabled in reset
`define OTCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otcr check failed");

`endif

/* rtl/otcr_pkg.sv */
// Shared types, constants and the 6x8 font table of the OLED text console.
// No dependencies.
package otcr_pkg;

  localparam int COL_W  = 8;
  localparam int PAGE_W = 3;
  localparam int ROW_W  = 7;
  localparam int STEP_W = 4;

  localparam int WRAP_COLUMN_DEF = 120;
  localparam int TAB_WIDTH_DEF   = 24;
  localparam int PAGE_COUNT_DEF  = 8;

  localparam int GLYPH_COLS  = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd122;
  localparam logic [7:0] CHAR_QMARK  = 8'h3f;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  // back-end sequencer steps: glyph columns first, then position commands
  localparam logic [STEP_W-1:0] STEP_FIRST_GLYPH = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LAST_GLYPH  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_POS_PAGE    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_POS_LOW     = 4'd7;
  localparam logic [STEP_W-1:0] STEP_POS_HIGH    = 4'd8;

  typedef struct packed {
    logic              glyph;   // emit six glyph columns
    logic              invert;  // unknown code: inverted '?'
    logic [ROW_W-1:0]  row;
    logic              pos;     // emit three position commands
    logic [PAGE_W-1:0] page;    // cursor after the move
    logic [COL_W-1:0]  col;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [47:0] font_row(input logic [ROW_W-1:0] idx);
    logic [47:0] r;
    unique case (idx)
      7'd0:  r = 48'h000000000000;
      7'd1:  r = 48'h0000002f0000;
      7'd2:  r = 48'h000007000700;
      7'd3:  r = 48'h00147f147f14;
      7'd4:  r = 48'h00242a7f2a12;
      7'd5:  r = 48'h006264081323;
      7'd6:  r = 48'h003649552250;
      7'd7:  r = 48'h000005030000;
      7'd8:  r = 48'h00001c224100;
      7'd9:  r = 48'h000041221c00;
      7'd10: r = 48'h0014083e0814;
      7'd11: r = 48'h0008083e0808;
      7'd12: r = 48'h000000a06000;
      7'd13: r = 48'h000808080808;
      7'd14: r = 48'h000060600000;
      7'd15: r = 48'h002010080402;
      7'd16: r = 48'h003e5149453e;
      7'd17: r = 48'h0000427f4000;
      7'd18: r = 48'h004261514946;
      7'd19: r = 48'h002141454b31;
      7'd20: r = 48'h001814127f10;
      7'd21: r = 48'h002745454539;
      7'd22: r = 48'h003c4a494930;
      7'd23: r = 48'h000171090503;
      7'd24: r = 48'h003649494936;
      7'd25: r = 48'h00064949291e;
      7'd26: r = 48'h000036360000;
      7'd27: r = 48'h000056360000;
      7'd28: r = 48'h000814224100;
      7'd29: r = 48'h001414141414;
      7'd30: r = 48'h000041221408;
      7'd31: r = 48'h000201510906;
      7'd32: r = 48'h00324959513e;
      7'd33: r = 48'h007c1211127c;
      7'd34: r = 48'h007f49494936;
      7'd35: r = 48'h003e41414122;
      7'd36: r = 48'h007f4141221c;
      7'd37: r = 48'h007f49494941;
      7'd38: r = 48'h007f09090901;
      7'd39: r = 48'h003e4149497a;
      7'd40: r = 48'h007f0808087f;
      7'd41: r = 48'h0000417f4100;
      7'd42: r = 48'h002040413f01;
      7'd43: r = 48'h007f08142241;
      7'd44: r = 48'h007f40404040;
      7'd45: r = 48'h007f020c027f;
      7'd46: r = 48'h007f0408107f;
      7'd47: r = 48'h003e4141413e;
      7'd48: r = 48'h007f09090906;
      7'd49: r = 48'h003e4151215e;
      7'd50: r = 48'h007f09192946;
      7'd51: r = 48'h004649494931;
      7'd52: r = 48'h0001017f0101;
      7'd53: r = 48'h003f4040403f;
      7'd54: r = 48'h001f2040201f;
      7'd55: r = 48'h003f4038403f;
      7'd56: r = 48'h006314081463;
      7'd57: r = 48'h000708700807;
      7'd58: r = 48'h006151494543;
      7'd59: r = 48'h00007f414100;
      7'd60: r = 48'h00552a552a55;
      7'd61: r = 48'h000041417f00;
      7'd62: r = 48'h000402010204;
      7'd63: r = 48'h004040404040;
      7'd64: r = 48'h000001020400;
      7'd65: r = 48'h002054545478;
      7'd66: r = 48'h007f48444438;
      7'd67: r = 48'h003844444420;
      7'd68: r = 48'h00384444487f;
      7'd69: r = 48'h003854545418;
      7'd70: r = 48'h00087e090102;
      7'd71: r = 48'h0018a4a4a47c;
      7'd72: r = 48'h007f08040478;
      7'd73: r = 48'h0000447d4000;
      7'd74: r = 48'h004080847d00;
      7'd75: r = 48'h007f10284400;
      7'd76: r = 48'h0000417f4000;
      7'd77: r = 48'h007c04180478;
      7'd78: r = 48'h007c08040478;
      7'd79: r = 48'h003844444438;
      7'd80: r = 48'h00fc24242418;
      7'd81: r = 48'h0018242418fc;
      7'd82: r = 48'h007c08040408;
      7'd83: r = 48'h004854545420;
      7'd84: r = 48'h00043f444020;
      7'd85: r = 48'h003c4040207c;
      7'd86: r = 48'h001c2040201c;
      7'd87: r = 48'h003c4030403c;
      7'd88: r = 48'h004428102844;
      7'd89: r = 48'h001ca0a0a07c;
      7'd90: r = 48'h004464544c44;
      default: r = 48'h000000000000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/otcr_queue.sv */
// Short job queue between the classifying front end and the byte sequencer.
// Depends on otcr_pkg and oled_text_cursor_renderer_unit_macros.svh.
`include "oled_text_cursor_renderer_unit_macros.svh"
module otcr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  otcr_pkg::job_t     wr_job,
  input  logic               rd_en,
  output otcr_pkg::job_t     rd_job,
  output otcr_pkg::q_status_t stat
);
  import otcr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wr_ok;

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign wr_ok      = wr_en && !stat.full;
  assign rd_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_ok && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_ok && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  `OTCR_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH))
  `OTCR_ASSERT_IMPL(a_no_underflow, clk, rst_n, rd_en, cnt_r != '0)
  `OTCR_ASSERT_NEXT(a_push_only, clk, rst_n, wr_ok && !rd_en, cnt_r == CNT_W'($past(cnt_r) + 1'b1))

endmodule

/* rtl/otcr_front.sv */
// Front end: takes characters, moves the text cursor and posts one job each.
// Depends on otcr_pkg.
module otcr_front #(
  parameter int WRAP_COLUMN = otcr_pkg::WRAP_COLUMN_DEF,
  parameter int TAB_WIDTH   = otcr_pkg::TAB_WIDTH_DEF,
  parameter int PAGE_COUNT  = otcr_pkg::PAGE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [7:0]          in_char_code,
  output logic                in_full,
  input  otcr_pkg::q_status_t q_stat,
  output logic                wr_en,
  output otcr_pkg::job_t      wr_job
);
  import otcr_pkg::*;

  localparam int PH_W  = $clog2(TAB_WIDTH);
  localparam int PHS_W = PH_W + 1;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;   // col_r mod TAB_WIDTH, kept incrementally

  logic              accept;
  logic              known;
  logic [PAGE_W-1:0] page_inc;
  logic [COL_W:0]    tab_col;
  logic [COL_W:0]    glyph_col;
  logic [PHS_W-1:0]  phase_add;
  logic [7:0]        row_code;

  assign in_full = q_stat.full;
  assign accept  = in_push && !q_stat.full;
  assign wr_en   = accept;

  assign known     = (in_char_code >= GLYPH_FIRST) && (in_char_code <= GLYPH_LAST);
  assign page_inc  = (page_r == PAGE_W'(PAGE_COUNT - 1)) ? '0 : page_r + 1'b1;
  assign tab_col   = {1'b0, col_r} + (COL_W+1)'(TAB_WIDTH) - (COL_W+1)'(phase_r);
  assign glyph_col = {1'b0, col_r} + (COL_W+1)'(GLYPH_COLS);
  assign phase_add = {1'b0, phase_r} + PHS_W'(GLYPH_COLS);
  assign row_code  = (known ? in_char_code : CHAR_QMARK) - GLYPH_FIRST;

  always_comb begin
    col_nxt   = '0;
    page_nxt  = page_r;
    phase_nxt = '0;
    wr_job.glyph  = 1'b0;
    wr_job.invert = 1'b0;
    wr_job.row    = '0;
    wr_job.pos    = 1'b1;
    priority if (in_char_code == CHAR_LF) begin
      page_nxt = page_inc;
    end else if (in_char_code == CHAR_CR) begin
      page_nxt = page_r;
    end else if (in_char_code == CHAR_TAB) begin
      if (tab_col > (COL_W+1)'(WRAP_COLUMN)) begin
        page_nxt = page_inc;
      end else begin
        col_nxt = tab_col[COL_W-1:0];
      end
    end else begin
      wr_job.glyph  = 1'b1;
      wr_job.invert = !known;
      wr_job.row    = row_code[ROW_W-1:0];
      if (glyph_col > (COL_W+1)'(WRAP_COLUMN)) begin
        page_nxt = page_inc;
      end else begin
        wr_job.pos = 1'b0;
        col_nxt    = glyph_col[COL_W-1:0];
        phase_nxt  = (phase_add >= PHS_W'(TAB_WIDTH)) ?
                     PH_W'(phase_add - PHS_W'(TAB_WIDTH)) : phase_add[PH_W-1:0];
      end
    end
    wr_job.page = page_nxt;
    wr_job.col  = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      page_r  <= '0;
      phase_r <= '0;
    end else if (accept) begin
      col_r   <= col_nxt;
      page_r  <= page_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

/* rtl/otcr_back.sv */
// Back end: walks each job and puts one controller byte a cycle in the output register while it is empty or popped.
// Depends on otcr_pkg and oled_text_cursor_renderer_unit_macros.svh.
`include "oled_text_cursor_renderer_unit_macros.svh"
module otcr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  otcr_pkg::q_status_t q_stat,
  input  otcr_pkg::job_t      q_job,
  output logic                q_rd,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_byte,
  output logic                out_is_command,
  output logic                out_last_of_run
);
  import otcr_pkg::*;

  job_t              job_r;
  logic              active_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_cmd_r;
  logic              out_last_r;

  logic              advance, emit, is_last, take;
  logic [47:0]       glyph_bits;
  logic [7:0]        glyph_byte;
  logic [7:0]        byte_nxt;
  logic              cmd_nxt;

  assign advance = !out_valid_r || out_pop;
  assign emit    = active_r && advance;
  assign is_last = job_r.pos ? (step_r == STEP_POS_HIGH) : (step_r == STEP_LAST_GLYPH);
  assign take    = !q_stat.empty && (!active_r || (emit && is_last));
  assign q_rd    = take;

  assign glyph_bits = font_row(job_r.row);

  always_comb begin
    glyph_byte = '0;
    byte_nxt   = '0;
    cmd_nxt    = 1'b1;
    unique case (step_r)
      4'd0: glyph_byte = glyph_bits[47:40];
      4'd1: glyph_byte = glyph_bits[39:32];
      4'd2: glyph_byte = glyph_bits[31:24];
      4'd3: glyph_byte = glyph_bits[23:16];
      4'd4: glyph_byte = glyph_bits[15:8];
      default: glyph_byte = glyph_bits[7:0];
    endcase
    priority if (step_r == STEP_POS_PAGE) begin
      byte_nxt = CMD_PAGE_BASE | 8'(job_r.page);
    end else if (step_r == STEP_POS_LOW) begin
      byte_nxt = {4'h0, job_r.col[3:0]};
    end else if (step_r == STEP_POS_HIGH) begin
      byte_nxt = CMD_COL_HIGH | {4'h0, job_r.col[7:4]};
    end else begin
      cmd_nxt  = 1'b0;
      byte_nxt = job_r.invert ? ~glyph_byte : glyph_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (take) begin
        active_r <= 1'b1;
        step_r   <= q_job.glyph ? STEP_FIRST_GLYPH : STEP_POS_PAGE;
      end else if (emit && is_last) begin
        active_r <= 1'b0;
      end else if (emit) begin
        step_r <= step_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= q_job;
    end
    if (emit) begin
      out_byte_r <= byte_nxt;
      out_cmd_r  <= cmd_nxt;
      out_last_r <= is_last;
    end
  end

  assign out_empty       = !out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_is_command  = out_cmd_r;
  assign out_last_of_run = out_last_r;

  `OTCR_ASSERT_IMPL(a_step_range, clk, rst_n, active_r, step_r <= STEP_POS_HIGH)
  `OTCR_ASSERT_IMPL(a_cmd_only_start, clk, rst_n, active_r && !job_r.glyph, step_r >= STEP_POS_PAGE)
  `OTCR_ASSERT_NEXT(a_last_flag, clk, rst_n, emit && is_last, out_valid_r && out_last_r)

endmodule

/* rtl/oled_text_cursor_renderer_unit.sv */
// Text console for a page-addressed OLED controller: characters in, controller bytes out.
// Path: an accepted character goes through the job queue and the back end's job register into the output register.
// Throughput: one byte per cycle while the output is empty or popped; a character makes 3, 6 or 9
// bytes for the byte sequencer (position only, glyph, glyph plus wrap).
// Reset: synchronous active-low rst_n; cursor at column 0, page 0, queue and output empty.
module oled_text_cursor_renderer_unit #(
  parameter int WRAP_COLUMN = otcr_pkg::WRAP_COLUMN_DEF,
  parameter int TAB_WIDTH   = otcr_pkg::TAB_WIDTH_DEF,
  parameter int PAGE_COUNT  = otcr_pkg::PAGE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char_code,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic       out_last_of_run
);
  import otcr_pkg::*;

  q_status_t q_stat;
  job_t      wr_job, rd_job;
  logic      wr_en, rd_en;

  otcr_front #(
    .WRAP_COLUMN (WRAP_COLUMN),
    .TAB_WIDTH   (TAB_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_char_code (in_char_code),
    .in_full      (in_full),
    .q_stat       (q_stat),
    .wr_en        (wr_en),
    .wr_job       (wr_job)
  );

  otcr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_job (wr_job),
    .rd_en  (rd_en),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  otcr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_job           (rd_job),
    .q_rd            (rd_en),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_is_command  (out_is_command),
    .out_last_of_run (out_last_of_run)
  );

endmodule
